### design/tkn_pkg.sv
// tkn_pkg: shared types and constants of the top-k nearest selector
// depends on nothing; used by top_k_nearest_selector by scoped names
`default_nettype none

package tkn_pkg;

    // field widths fixed by the interface
    localparam int ACC_W  = 25;
    localparam int ID_W   = 32;
    localparam int VAL_W  = 8;
    localparam int SQ_W   = 2 * VAL_W;
    localparam int RANK_W = 4;

    typedef logic [ACC_W-1:0] acc_t;
    typedef logic [ID_W-1:0]  id_t;
    typedef logic [VAL_W-1:0] val_t;
    typedef logic [SQ_W-1:0]  sq_t;

    // saturation value of the distance accumulator
    localparam acc_t ACC_MAX = {ACC_W{1'b1}};

    // id reported for an unfilled slot
    localparam id_t NOT_FOUND_ID = {ID_W{1'b1}};

    // operation codes
    localparam logic OP_ELEMENT   = 1'b0;
    localparam logic OP_END_QUERY = 1'b1;

    // request from the distance stage to the list stage
    typedef struct packed {
        logic flush;
        acc_t distance;
        id_t  id;
    } list_req_t;

endpackage

`default_nettype wire

### design/top_k_nearest_selector.sv
// top_k_nearest_selector: streaming squared-distance accumulator and sorted top-k list
// depends on tkn_pkg (types, widths, op codes)
//
//  channel | signals                                                   | dir
//  --------+-----------------------------------------------------------+-----
//  in      | in_valid, in_ready, operation, candidate_id, base_value,  | in
//          | query_value, last_element                                 |
//  out     | out_valid, out_ready, rank, neighbor_id, found,           | out
//          | last_result                                               |
//
// one input word is taken every cycle while in_ready is high; a word passes an input
// register and the square-accumulate stage, whose register writes a closed candidate
// into the list
// an end-of-query word takes the same path and then loads TOP_K result words into an
// output shift register, which sends one word per cycle while out_ready is high and
// input streams on; in_ready drops only while an end-of-query word waits at the list
// stage and the previous query's results are still draining
// rst_n clears the accumulator, the list and the output register at once
`default_nettype none

module top_k_nearest_selector #(
    parameter int TOP_K = 10
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      operation,
    input  wire logic [tkn_pkg::ID_W-1:0]  candidate_id,
    input  wire logic [tkn_pkg::VAL_W-1:0] base_value,
    input  wire logic [tkn_pkg::VAL_W-1:0] query_value,
    input  wire logic                      last_element,

    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [tkn_pkg::RANK_W-1:0]     rank,
    output logic [tkn_pkg::ID_W-1:0]       neighbor_id,
    output logic                           found,
    output logic                           last_result
);

    localparam int IDX_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TOP_K - 1);

    // pipeline advance: holds only for a flush blocked by draining results
    logic adv;

    // input register
    logic             s0_valid_reg;
    logic             s0_op_reg;
    tkn_pkg::id_t     s0_id_reg;
    tkn_pkg::val_t    s0_base_reg;
    tkn_pkg::val_t    s0_query_reg;
    logic             s0_last_reg;

    // distance stage
    tkn_pkg::acc_t    acc_reg;
    tkn_pkg::acc_t    acc_next;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    tkn_pkg::list_req_t s1_req_reg;
    tkn_pkg::list_req_t s1_req_next;
    tkn_pkg::val_t    abs_diff;
    tkn_pkg::sq_t     sq;
    logic [tkn_pkg::ACC_W:0] acc_sum;
    tkn_pkg::acc_t    acc_sat;

    // sorted list
    tkn_pkg::acc_t    list_dist_reg  [TOP_K];
    tkn_pkg::acc_t    list_dist_next [TOP_K];
    tkn_pkg::id_t     list_id_reg    [TOP_K];
    tkn_pkg::id_t     list_id_next   [TOP_K];
    logic [TOP_K-1:0] list_valid_reg;
    logic [TOP_K-1:0] list_valid_next;
    tkn_pkg::acc_t    up_dist [TOP_K];
    tkn_pkg::id_t     up_id   [TOP_K];
    logic [TOP_K-1:0] better;
    logic [TOP_K-1:0] better_prev;
    logic             do_ins;

    // output shift register
    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    tkn_pkg::id_t     out_id_reg    [TOP_K];
    logic [TOP_K-1:0] out_found_reg;
    logic             snap;
    logic             out_take;

    assign adv      = !(s1_valid_reg && s1_req_reg.flush && busy_reg);
    assign in_ready = adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            s0_op_reg    <= operation;
            s0_id_reg    <= candidate_id;
            s0_base_reg  <= base_value;
            s0_query_reg <= query_value;
            s0_last_reg  <= last_element;
        end
    end

    // square and saturating accumulate
    assign abs_diff = (s0_base_reg >= s0_query_reg) ? (s0_base_reg - s0_query_reg)
                                                    : (s0_query_reg - s0_base_reg);
    assign sq       = tkn_pkg::SQ_W'(abs_diff * abs_diff);
    assign acc_sum  = {1'b0, acc_reg} + (tkn_pkg::ACC_W + 1)'(sq);
    assign acc_sat  = acc_sum[tkn_pkg::ACC_W] ? tkn_pkg::ACC_MAX
                                              : acc_sum[tkn_pkg::ACC_W-1:0];

    always_comb
    begin
        acc_next             = acc_reg;
        s1_valid_next        = 1'b0;
        s1_req_next.flush    = (s0_op_reg == tkn_pkg::OP_END_QUERY);
        s1_req_next.distance = acc_sat;
        s1_req_next.id       = s0_id_reg;
        if (s0_valid_reg)
        begin
            if (s0_op_reg == tkn_pkg::OP_END_QUERY)
            begin
                acc_next      = '0;
                s1_valid_next = 1'b1;
            end
            else if (s0_last_reg)
            begin
                acc_next      = '0;
                s1_valid_next = 1'b1;
            end
            else
            begin
                acc_next = acc_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            acc_reg      <= acc_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_next)
        begin
            s1_req_reg <= s1_req_next;
        end
    end

    // neighbor entry one slot up, used when the list shifts down
    genvar g;
    generate
        for (g = 0; g < TOP_K; g++)
        begin : g_up
            if (g == 0)
            begin : g_first
                assign up_dist[g] = '0;
                assign up_id[g]   = '0;
            end
            else
            begin : g_rest
                assign up_dist[g] = list_dist_reg[g-1];
                assign up_id[g]   = list_id_reg[g-1];
            end
        end
    endgenerate

    // parallel compare: slot holds an entry not ahead of the new candidate
    always_comb
    begin
        for (int i = 0; i < TOP_K; i++)
        begin
            better[i] = !list_valid_reg[i]
                     || (list_dist_reg[i] > s1_req_reg.distance)
                     || ((list_dist_reg[i] == s1_req_reg.distance)
                         && (list_id_reg[i] >= s1_req_reg.id));
        end
    end

    assign better_prev = better << 1;
    assign do_ins = !(list_valid_reg[TOP_K-1]
                      && (s1_req_reg.distance >= list_dist_reg[TOP_K-1]));

    // compare-shift insert and clear on end of query
    always_comb
    begin
        list_valid_next = list_valid_reg;
        for (int i = 0; i < TOP_K; i++)
        begin
            list_dist_next[i] = list_dist_reg[i];
            list_id_next[i]   = list_id_reg[i];
        end
        if (s1_valid_reg && adv)
        begin
            if (s1_req_reg.flush)
            begin
                list_valid_next = '0;
            end
            else if (do_ins)
            begin
                for (int i = 0; i < TOP_K; i++)
                begin
                    if (better_prev[i])
                    begin
                        list_dist_next[i]  = up_dist[i];
                        list_id_next[i]    = up_id[i];
                        list_valid_next[i] = list_valid_reg[i-1 >= 0 ? i-1 : 0];
                    end
                    else if (better[i])
                    begin
                        list_dist_next[i]  = s1_req_reg.distance;
                        list_id_next[i]    = s1_req_reg.id;
                        list_valid_next[i] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_valid_reg <= '0;
        end
        else
        begin
            list_valid_reg <= list_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TOP_K; i++)
        begin
            list_dist_reg[i] <= list_dist_next[i];
            list_id_reg[i]   <= list_id_next[i];
        end
    end

    // output shift register: snapshot on end of query, one word per cycle while out_ready is high
    assign snap     = s1_valid_reg && s1_req_reg.flush && adv;
    assign out_take = busy_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (snap)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (out_take)
        begin
            if (idx_reg == IDX_LAST)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap)
        begin
            for (int i = 0; i < TOP_K; i++)
            begin
                out_id_reg[i] <= list_valid_reg[i] ? list_id_reg[i]
                                                   : tkn_pkg::NOT_FOUND_ID;
            end
            out_found_reg <= list_valid_reg;
        end
        else if (out_take)
        begin
            for (int i = 0; i < TOP_K - 1; i++)
            begin
                out_id_reg[i] <= out_id_reg[i+1];
            end
            out_found_reg <= out_found_reg >> 1;
        end
    end

    assign out_valid   = busy_reg;
    assign rank        = tkn_pkg::RANK_W'(idx_reg);
    assign neighbor_id = out_id_reg[0];
    assign found       = out_found_reg[0];
    assign last_result = (idx_reg == IDX_LAST);

    // checks

    // pipeline holds only while results of the previous query drain
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> busy_reg)
        else $error("input stalled while output register idle");

    // an end-of-query word starts a fresh sequence at rank zero
    assert property (@(posedge clk) disable iff (!rst_n)
        snap |=> (busy_reg && (idx_reg == '0)))
        else $error("result sequence did not restart at rank zero");

    // nothing follows the final result of a query in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && last_result) |=> !out_valid)
        else $error("result word after final rank");

    // list stays packed and sorted by distance then id
    generate
        for (g = 0; g < TOP_K - 1; g++)
        begin : g_chk
            assert property (@(posedge clk) disable iff (!rst_n)
                list_valid_reg[g+1] |-> (list_valid_reg[g]
                    && ((list_dist_reg[g] < list_dist_reg[g+1])
                        || ((list_dist_reg[g] == list_dist_reg[g+1])
                            && (list_id_reg[g] <= list_id_reg[g+1])))))
                else $error("nearest list out of order");
        end
    endgenerate

endmodule

`default_nettype wire

### verif/top_k_nearest_selector_checker.sv
`timescale 1ns / 1ps
// top_k_nearest_selector_checker: watches both channels, predicts the ranked words and compares
// depends on tkn_pkg (widths, types, op codes, not-found id)

module top_k_nearest_selector_checker
    import tkn_pkg::*;
#(
    parameter int TOP_K = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              operation,
    input  wire logic [ID_W-1:0]   candidate_id,
    input  wire logic [VAL_W-1:0]  base_value,
    input  wire logic [VAL_W-1:0]  query_value,
    input  wire logic              last_element,

    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic [RANK_W-1:0] rank,
    input  wire logic [ID_W-1:0]   neighbor_id,
    input  wire logic              found,
    input  wire logic              last_result,

    output int                     errors,
    output int                     pending,
    output int                     n_queries,
    output int                     n_candidates,
    output int                     n_words
);

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        id_t               id;
        logic              found;
        logic              last;
    } ranked_word_t;

    // predicted state: running distance and the sorted nearest list
    acc_t         running_dist;
    acc_t         best_dist [TOP_K];
    id_t          best_id   [TOP_K];
    logic         slot_used [TOP_K];

    ranked_word_t expected_ranking [$];
    ranked_word_t want;

    function void clear_ranking();
        for (int i = 0; i < TOP_K; i++)
        begin
            best_dist[i] = '0;
            best_id[i]   = '0;
            slot_used[i] = 1'b0;
        end
        running_dist = '0;
    endfunction

    // sorted insert: by distance, then id; a new entry goes ahead of an equal one
    function void insert_neighbor(acc_t new_dist, id_t id);
        int pos;
        if (slot_used[TOP_K-1] && new_dist >= best_dist[TOP_K-1])
            return;
        pos = TOP_K - 1;
        for (int i = 0; i < TOP_K; i++)
        begin
            if (!slot_used[i] || best_dist[i] > new_dist ||
                (best_dist[i] == new_dist && best_id[i] >= id))
            begin
                pos = i;
                break;
            end
        end
        for (int i = TOP_K - 1; i > pos; i--)
        begin
            best_dist[i] = best_dist[i-1];
            best_id[i]   = best_id[i-1];
            slot_used[i] = slot_used[i-1];
        end
        best_dist[pos] = new_dist;
        best_id[pos]   = id;
        slot_used[pos] = 1'b1;
    endfunction

    // saturating square-accumulate, candidate closes on its last element
    function void fold_element(val_t b, val_t q, logic closes, id_t id);
        int              diff;
        logic [ACC_W:0]  sq_ext;
        logic [ACC_W:0]  sum;
        acc_t            closed_dist;
        diff   = int'(b) - int'(q);
        sq_ext = (ACC_W + 1)'(diff * diff);
        sum    = {1'b0, running_dist} + sq_ext;
        running_dist = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
        if (closes)
        begin
            closed_dist  = running_dist;
            running_dist = '0;
            insert_neighbor(closed_dist, id);
            n_candidates++;
        end
    endfunction

    // end of query: one word per slot, then the list starts over
    function void emit_ranking();
        ranked_word_t w;
        for (int k = 0; k < TOP_K; k++)
        begin
            w.rank  = RANK_W'(k);
            w.id    = slot_used[k] ? best_id[k] : NOT_FOUND_ID;
            w.found = slot_used[k];
            w.last  = (k == TOP_K - 1);
            expected_ranking = {expected_ranking, w};
        end
        clear_ranking();
        n_queries++;
    endfunction

    function void check_field(string what, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h actual %h",
                     $time, what, exp_val, act_val);
        end
    endfunction

    // compare outgoing words, then predict from the incoming word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_ranking();
            expected_ranking.delete();
            errors       = 0;
            n_queries    = 0;
            n_candidates = 0;
            n_words      = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_ranking.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected word, expected none actual rank %h id %h",
                             $time, rank, neighbor_id);
                end
                else
                begin
                    want = expected_ranking.pop_front();
                    check_field("rank", 32'(want.rank), 32'(rank));
                    check_field("neighbor_id", want.id, neighbor_id);
                    check_field("found", 32'(want.found), 32'(found));
                    check_field("last_result", 32'(want.last), 32'(last_result));
                    n_words++;
                end
            end
            if (in_valid && in_ready)
            begin
                if (operation == OP_END_QUERY)
                    emit_ranking();
                else
                    fold_element(base_value, query_value, last_element, candidate_id);
            end
        end
        pending = expected_ranking.size();
    end

endmodule

### verif/top_k_nearest_selector_tb.sv
`timescale 1ns / 1ps
// top_k_nearest_selector_tb: drives element and end-of-query words into the selector
// depends on tkn_pkg, top_k_nearest_selector and top_k_nearest_selector_checker

module top_k_nearest_selector_tb;
    import tkn_pkg::*;

    localparam int TOP_K         = 10;
    localparam int RANDOM_ITEMS  = 260;
    localparam int CALM_ITEMS    = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic              operation    = OP_ELEMENT;
    id_t               candidate_id = '0;
    val_t              base_value   = '0;
    val_t              query_value  = '0;
    logic              last_element = 1'b0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [RANK_W-1:0] rank;
    id_t               neighbor_id;
    logic              found;
    logic              last_result;

    int   errors;
    int   pending;
    int   n_queries;
    int   n_candidates;
    int   n_words;
    int   items_sent = 0;
    logic calm       = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_seen  = 1'b0;

    always #2 clk = ~clk;

    top_k_nearest_selector #(
        .TOP_K (TOP_K)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .candidate_id (candidate_id),
        .base_value   (base_value),
        .query_value  (query_value),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rank         (rank),
        .neighbor_id  (neighbor_id),
        .found        (found),
        .last_result  (last_result)
    );

    top_k_nearest_selector_checker #(
        .TOP_K (TOP_K)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .candidate_id (candidate_id),
        .base_value   (base_value),
        .query_value  (query_value),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rank         (rank),
        .neighbor_id  (neighbor_id),
        .found        (found),
        .last_result  (last_result),
        .errors       (errors),
        .pending      (pending),
        .n_queries    (n_queries),
        .n_candidates (n_candidates),
        .n_words      (n_words)
    );

    // one input word, after an optional idle burst; returns once accepted
    task automatic send_word(input logic op, input id_t id, input val_t b, input val_t q,
                             input logic closes);
        int gap;
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid     <= 1'b1;
            operation    <= op;
            candidate_id <= id;
            base_value   <= b;
            query_value  <= q;
            last_element <= closes;
            do
                @(posedge clk);
            while (!in_ready);
            items_sent++;
        end
    endtask

    // a candidate of random elements; closes = 0 leaves it unfinished
    task automatic send_candidate(input id_t id, input int dim, input int max_val,
                                  input logic closes);
        for (int d = 0; d < dim; d++)
            send_word(OP_ELEMENT, id, val_t'($urandom_range(0, max_val)),
                      val_t'($urandom_range(0, max_val)), closes && (d == dim - 1));
    endtask

    // end of query with junk in the ignored fields
    task automatic send_end();
        send_word(OP_END_QUERY, $urandom, val_t'($urandom_range(0, 255)),
                  val_t'($urandom_range(0, 255)), logic'($urandom_range(0, 1)));
    endtask

    // receiver: random stall bursts, a long hold on request, none once calm
    initial
    begin : receiver
        int stall;
        int held;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                out_ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_seen = hold_req;
            end
            else if (calm)
                out_ready <= 1'b1;
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 8) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int   goal;
        int   ncand;
        int   dim;
        int   max_val;
        int   waited;
        id_t  id;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty list: every slot reports not found
        send_word(OP_END_QUERY, '1, 8'hFF, 8'hFF, 1'b1);

        // extreme values and ids, equal distances, equal ids
        send_word(OP_ELEMENT, 32'h0000_0000, 8'h00, 8'hFF, 1'b1);
        send_word(OP_ELEMENT, 32'hFFFF_FFFF, 8'hFF, 8'h00, 1'b1);
        send_word(OP_ELEMENT, 32'd5, 8'h07, 8'h07, 1'b1);
        send_word(OP_ELEMENT, 32'd5, 8'hA5, 8'hA5, 1'b1);
        // unfinished candidate is dropped at end of query
        send_word(OP_ELEMENT, 32'd9, 8'h03, 8'h00, 1'b0);
        send_end();

        // fill the list, offer a tie with the worst, then displace the worst
        for (int i = 1; i <= TOP_K; i++)
            send_word(OP_ELEMENT, 100 + i, val_t'(i), 8'h00, 1'b1);
        send_word(OP_ELEMENT, 32'd1, 8'h00, val_t'(TOP_K), 1'b1);
        send_word(OP_ELEMENT, 32'd200, 8'h00, 8'h00, 1'b1);
        send_end();

        // hold the output side while queries keep coming
        hold_req <= ~hold_req;
        for (int qn = 0; qn < 4; qn++)
        begin
            send_candidate($urandom, 1, 255, 1'b1);
            send_candidate($urandom, 1, 255, 1'b1);
            send_end();
        end

        // random queries: mostly whole candidates, sometimes a broken tail
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            if (items_sent >= goal - CALM_ITEMS)
                calm = 1'b1;
            ncand   = $urandom_range(0, 14);
            max_val = ($urandom_range(0, 2) == 0) ? 3 : 255;
            for (int c = 0; c < ncand; c++)
            begin
                dim = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12)
                                                  : $urandom_range(1, 4);
                id  = ($urandom_range(0, 2) == 0) ? id_t'($urandom_range(0, 7)) : $urandom;
                send_candidate(id, dim, max_val, 1'b1);
            end
            if ($urandom_range(0, 7) == 0)
                send_candidate($urandom, $urandom_range(1, 3), max_val, 1'b0);
            send_end();
        end
        in_valid <= 1'b0;

        // drain and settle
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d queries, %0d closed candidates, %0d ranked words compared",
                 n_queries, n_candidates, n_words);
        $display("including an empty list, ties, a full list and a held output");
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
